/* hdl/hgld_pkg.sv */
// Shared widths and controller/datapath interface types for the hex grid line drawer.
package hgld_pkg;

    // Field widths on the ports.
    localparam int COORD_W = 5;
    localparam int S_W     = 6;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // Internal widths, sized for the largest supported coordinate limit.
    localparam int DELTA_W = 7;   // q, r and s deltas, signed
    localparam int N_W     = 6;   // hex distance, unsigned
    localparam int INT_W   = 7;   // integer part of a coordinate, signed
    localparam int REM_W   = 8;   // remainder plus one delta, signed
    localparam int KEY_W   = 9;   // rounding difference ordering key

    typedef struct packed {
        logic load;   // capture the endpoints of a new item
        logic init;   // compute the distance and clear the walk state
        logic step;   // emit the current cell and advance one step
    } t_dp_cmd;

    typedef struct packed {
        logic done;   // the current cell is the end cell
    } t_dp_status;

endpackage

/* hdl/hgld_ctrl.sv */
// Sequencing state machine for the hex grid line drawer.
module hgld_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  hgld_pkg::t_dp_status i_status,
    output hgld_pkg::t_dp_cmd   o_cmd
);
    import hgld_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;

    assign slot_free  = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.init = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.init = 1'b1;
                n_state    = ST_RUN;
            end
            ST_RUN: begin
                if (slot_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.done) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The output slot refills on a step; otherwise it empties when the sink takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.step) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hdl/hgld_dp.sv */
// Datapath: endpoint capture, distance, exact incremental walk and cube rounding.
module hgld_dp #(
    parameter int COORD_LIMIT = 15
) (
    input  logic                      i_clk,
    input  logic [hgld_pkg::IN_TDATA_W-1:0] i_tdata,
    input  hgld_pkg::t_dp_cmd         i_cmd,
    output hgld_pkg::t_dp_status      o_status,
    output logic [hgld_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic                      o_tlast
);
    import hgld_pkg::*;

    localparam logic signed [COORD_W-1:0] LIM_POS = COORD_W'(COORD_LIMIT);
    localparam logic signed [COORD_W-1:0] LIM_NEG = COORD_W'(-COORD_LIMIT);

    function automatic logic signed [COORD_W-1:0] clamp(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W-1:0] c;
        c = v;
        if (v > LIM_POS) begin
            c = LIM_POS;
        end else if (v < LIM_NEG) begin
            c = LIM_NEG;
        end
        return c;
    endfunction

    function automatic logic [DELTA_W-1:0] absd(input logic signed [DELTA_W-1:0] v);
        return v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
    endfunction

    // One coordinate advanced by its delta, remainder kept in [0, den).
    function automatic logic [INT_W+REM_W-1:0] advance(
        input logic signed [INT_W-1:0]   ip,
        input logic signed [REM_W-1:0]   rm,
        input logic signed [DELTA_W-1:0] dl,
        input logic [N_W-1:0]            den
    );
        logic signed [REM_W-1:0] t;
        logic signed [REM_W-1:0] dn;
        logic signed [INT_W-1:0] ni;
        logic signed [REM_W-1:0] nr;
        t  = rm + REM_W'(dl);
        dn = $signed(REM_W'(den));
        ni = ip;
        nr = t;
        if (t >= dn) begin
            nr = t - dn;
            ni = ip + INT_W'(1);
        end else if (t < 0) begin
            nr = t + dn;
            ni = ip - INT_W'(1);
        end
        return {ni, nr};
    endfunction

    // Captured endpoints.
    logic signed [COORD_W-1:0] r_aq, r_ar, r_bq, r_br;
    // Walk state.
    logic signed [DELTA_W-1:0] r_dq, r_dr, r_ds;
    logic [N_W-1:0]            r_n, r_den, r_cnt;
    logic signed [INT_W-1:0]   r_iq, r_ir, r_is;
    logic signed [REM_W-1:0]   r_rq, r_rr, r_rs;
    // Output register.
    logic signed [COORD_W-1:0] r_cell_q, r_cell_r;
    logic signed [S_W-1:0]     r_cell_s;
    logic                      r_last;

    // Distance.
    logic signed [DELTA_W-1:0] dq, dr, ds;
    logic [DELTA_W:0]          dsum;
    logic [N_W-1:0]            nn;

    assign dq   = DELTA_W'(r_bq) - DELTA_W'(r_aq);
    assign dr   = DELTA_W'(r_br) - DELTA_W'(r_ar);
    assign ds   = -dq - dr;
    assign dsum = (DELTA_W+1)'(absd(dq)) + (DELTA_W+1)'(absd(dr)) + (DELTA_W+1)'(absd(ds));
    assign nn   = N_W'(dsum >> 1);

    // Rounding of the current point.
    logic [N_W-1:0]          mq, mr, ms;
    logic [N_W:0]            twq, twr, tws;
    logic                    up_q, up_r, up_s;
    logic [KEY_W-1:0]        kq, kr, ks;
    logic signed [INT_W-1:0] qi, ri, si, fq, fr, fs;

    assign mq  = N_W'(r_rq);
    assign mr  = N_W'(r_rr);
    assign ms  = N_W'(r_rs);
    assign twq = {mq, 1'b0};
    assign twr = {mr, 1'b0};
    assign tws = {ms, 1'b0};
    // A q or r tie rounds up, an s tie rounds down.
    assign up_q = twq >= (N_W+1)'(r_den);
    assign up_r = twr >= (N_W+1)'(r_den);
    assign up_s = tws >  (N_W+1)'(r_den);

    assign qi = r_iq + INT_W'(up_q);
    assign ri = r_ir + INT_W'(up_r);
    assign si = r_is + INT_W'(up_s);

    // Keys order the rounding errors with the nudge as the tie-breaking minor term.
    always_comb begin
        kq = up_q ? {(KEY_W-3)'(r_den - mq), 3'b000} + KEY_W'(3)
                  : {(KEY_W-3)'(mq), 3'b000} + KEY_W'(5);
        kr = up_r ? {(KEY_W-3)'(r_den - mr), 3'b000} + KEY_W'(3)
                  : {(KEY_W-3)'(mr), 3'b000} + KEY_W'(5);
        if (up_s) begin
            ks = {(KEY_W-3)'(r_den - ms), 3'b000} + KEY_W'(6);
        end else if (ms == '0) begin
            ks = KEY_W'(6);
        end else begin
            ks = {(KEY_W-3)'(ms), 3'b000} + KEY_W'(2);
        end
    end

    always_comb begin
        fq = qi;
        fr = ri;
        fs = si;
        priority if (kq > kr && kq > ks) begin
            fq = -ri - si;
        end else if (kr > ks) begin
            fr = -qi - si;
        end else begin
            fs = -qi - ri;
        end
    end

    logic [INT_W+REM_W-1:0] adv_q, adv_r, adv_s;
    assign adv_q = advance(r_iq, r_rq, r_dq, r_den);
    assign adv_r = advance(r_ir, r_rr, r_dr, r_den);
    assign adv_s = advance(r_is, r_rs, r_ds, r_den);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_aq <= clamp(i_tdata[COORD_W-1:0]);
            r_ar <= clamp(i_tdata[2*COORD_W-1:COORD_W]);
            r_bq <= clamp(i_tdata[3*COORD_W-1:2*COORD_W]);
            r_br <= clamp(i_tdata[4*COORD_W-1:3*COORD_W]);
        end
        if (i_cmd.init) begin
            r_dq  <= dq;
            r_dr  <= dr;
            r_ds  <= ds;
            r_n   <= nn;
            r_den <= (nn == '0) ? N_W'(1) : nn;
            r_cnt <= '0;
            r_iq  <= INT_W'(r_aq);
            r_ir  <= INT_W'(r_ar);
            r_is  <= -INT_W'(r_aq) - INT_W'(r_ar);
            r_rq  <= '0;
            r_rr  <= '0;
            r_rs  <= '0;
        end else if (i_cmd.step) begin
            {r_iq, r_rq} <= adv_q;
            {r_ir, r_rr} <= adv_r;
            {r_is, r_rs} <= adv_s;
            r_cnt        <= r_cnt + N_W'(1);
        end
        if (i_cmd.step) begin
            r_cell_q <= COORD_W'(fq);
            r_cell_r <= COORD_W'(fr);
            r_cell_s <= S_W'(fs);
            r_last   <= (r_cnt == r_n);
        end
    end

    assign o_status.done = (r_cnt == r_n);
    assign o_tdata       = {r_cell_s, r_cell_r, r_cell_q};
    assign o_tlast       = r_last;

endmodule

/* hdl/hex_grid_line_draw.sv */
// Top level of the hex grid line drawer: controller, datapath and checks.
//
// Usage: one slave transfer on i_s_* carries a start and an end hex cell in
// cube coordinates (s is implied as -q-r). The block answers with the cells of
// the line between them, start first, one master transfer per cell on o_m_*,
// with o_m_tlast set on the end cell. The count of cells is the hex distance
// plus one, at most 4*COORD_LIMIT+1; equal endpoints give one cell.
// The input transfer captures the endpoints, the setup state computes the
// distance and the first walk step registers the first cell. The single walk
// unit then advances one cell per cycle while the receiver does not stall.
// A new item is taken only when the previous walk has finished; the last cell
// may still wait in the output register while the next item is taken.
// When the receiver stalls, the walk holds and the offered cell stays put.
// Reset (synchronous, active low) returns to idle and drops the output valid.
// Out-of-range coordinates (only -16 by default) are clamped to +-COORD_LIMIT.
module hex_grid_line_draw #(
    parameter int COORD_LIMIT = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // start_q [4:0], start_r [9:5], end_q [14:10], end_r [19:15], zero [23:20]
    input  logic [hgld_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // cell_q [4:0], cell_r [9:5], cell_s [15:10]
    output logic [hgld_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic        o_m_tlast
);
    import hgld_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    hgld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hgld_dp #(
        .COORD_LIMIT (COORD_LIMIT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_tdata  (i_s_tdata),
        .i_cmd    (cmd),
        .o_status (status),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

`ifndef ASSERT_OFF
    // After an input transfer the block is busy with setup and not ready in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted again right after a transfer");

    // Every emitted cell lies on the cube plane q + r + s = 0.
    a_cube_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed({{2{o_m_tdata[4]}}, o_m_tdata[4:0]})
                       + $signed({{2{o_m_tdata[9]}}, o_m_tdata[9:5]})
                       + $signed({o_m_tdata[15], o_m_tdata[15:10]})) == 7'sd0)
        else $error("emitted cell is off the cube plane");

    // Returning to idle coincides with the end cell being offered.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_s_tready) |-> (o_m_tvalid && o_m_tlast))
        else $error("walk ended without offering the end cell");
`endif

endmodule
